/* sv/rlva_pkg.sv */
// ----------------------------------------------------------------------------
// Rate-limited voltage averager package
// Shared widths, reset values and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rlva_pkg;

  // Field widths.
  localparam int TICK_W = 32;
  localparam int CODE_W = 12;
  localparam int REF_W  = 13;
  localparam int SHIFT_W = 2;
  localparam int VAL_W  = 15;
  localparam int PROD_W = CODE_W + REF_W;
  localparam int MV_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Default averaging depth.
  localparam int RLVA_DEPTH = 8;

  // Full-scale converter code.
  localparam logic [CODE_W-1:0] FULL_SCALE = 12'hFFF;

  // Reset values.
  localparam logic [TICK_W-1:0]  START_TICK      = 32'hE000_0000;
  localparam logic [TICK_W-1:0]  INTERVAL_RESET  = 32'd60000;
  localparam logic [REF_W-1:0]   REFERENCE_RESET = 13'd1210;
  localparam logic [SHIFT_W-1:0] GAIN_RESET      = 2'd2;
  localparam logic [SHIFT_W-1:0] GAIN_MAX        = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd2;

  // Load enables for the conversion pipeline stages.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } conv_en_t;

endpackage

`default_nettype wire

/* sv/rlva_cell.sv */
// ----------------------------------------------------------------------------
// Averaging window cell
// One entry of the sample window; shifts from its neighbor or takes a fill.
// ----------------------------------------------------------------------------
`default_nettype none

module rlva_cell (
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire logic                      fill,
  input  wire logic [rlva_pkg::VAL_W-1:0] fill_value,
  input  wire logic [rlva_pkg::VAL_W-1:0] shift_in,
  output logic      [rlva_pkg::VAL_W-1:0] value
);
  import rlva_pkg::*;

  // The first accepted sample fills the whole window; later ones shift in.
  always_ff @(posedge clk) begin
    if (load) begin
      value <= fill ? fill_value : shift_in;
    end
  end

endmodule

`default_nettype wire

/* sv/rlva_conv.sv */
// ----------------------------------------------------------------------------
// Code to millivolt converter
// Four-stage pipeline: multiply by reference, divide by 4095, apply gain.
// ----------------------------------------------------------------------------
`default_nettype none

module rlva_conv (
  input  wire logic                        clk,
  input  wire rlva_pkg::conv_en_t          en,
  input  wire logic [rlva_pkg::CODE_W-1:0]  adc_code,
  input  wire logic [rlva_pkg::REF_W-1:0]   reference_mv,
  input  wire logic [rlva_pkg::SHIFT_W-1:0] gain_shift,
  output logic      [rlva_pkg::VAL_W-1:0]   value
);
  import rlva_pkg::*;

  logic [CODE_W-1:0] code1;
  logic [PROD_W-1:0] prod2;
  logic [PROD_W-1:0] prod3;
  logic [MV_W-1:0]   est3;
  logic [PROD_W:0]   est_sum;
  logic [PROD_W-1:0] est_times_fs;
  logic [PROD_W-1:0] rem;
  logic [MV_W-1:0]   mv;
  logic [SHIFT_W-1:0] shift_sat;

  // Quotient estimate x*4097/2^24 is never above floor(x/4095) and at most one below.
  assign est_sum = {1'b0, prod2} + {13'd0, prod2[PROD_W-1:12]};

  // Remainder check fixes the estimate with a single compare.
  assign est_times_fs = {est3, 12'd0} - {12'd0, est3};
  assign rem = prod3 - est_times_fs;
  assign mv = (rem >= PROD_W'(FULL_SCALE)) ? est3 + MV_W'(1) : est3;

  // A gain code above two saturates at two.
  assign shift_sat = (gain_shift > GAIN_MAX) ? GAIN_MAX : gain_shift;

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      code1 <= adc_code;
    end
    if (en.ld2) begin
      prod2 <= PROD_W'(code1) * PROD_W'(reference_mv);
    end
    if (en.ld3) begin
      prod3 <= prod2;
      est3  <= est_sum[12 +: MV_W];
    end
    if (en.ld4) begin
      value <= VAL_W'({2'd0, mv} << shift_sat);
    end
  end

endmodule

`default_nettype wire

/* sv/rate_limited_voltage_averager_unit.sv */
// ----------------------------------------------------------------------------
// Rate-limited voltage averager
// Gates measurement triggers by elapsed time and averages accepted samples.
// ----------------------------------------------------------------------------
// Usage: each input word (now_ms, adc_code) is a measurement trigger. If the
// wrapping time since the last accepted trigger reaches interval_ms, the code
// is scaled to millivolts, pushed into a window of DEPTH cells and the window
// average is returned with reported set. Otherwise the last reported value is
// returned with reported clear. Every input word yields one output word.
// Words pass stages v1 to v6 into the output. Throughput is one word per
// cycle unless out_stall holds it; its loops are the timestamp compare and the
// running window sum. Each pipeline stage moves whenever the stage after it is
// empty or moving, so bubbles close up and a full pipeline stalls the input
// only when out_stall holds a waiting result. The output stays stable while
// stalled. Configuration writes are always taken (cfg_ready is high) and
// must only happen while the unit is idle. Reset clears the pipeline, the
// held value and the window state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module rate_limited_voltage_averager_unit #(
  parameter int DEPTH = rlva_pkg::RLVA_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rlva_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rlva_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rlva_pkg::TICK_W-1:0]     now_ms,
  input  wire logic [rlva_pkg::CODE_W-1:0]     adc_code,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                reported,
  output logic      [rlva_pkg::VAL_W-1:0]      voltage_mv
);
  import rlva_pkg::*;

  // Window sum width and exact reciprocal for floor(sum / DEPTH).
  localparam int L     = $clog2(DEPTH);
  localparam int SUM_W = VAL_W + L;
  localparam int SH    = SUM_W + L;
  localparam int MW    = SUM_W + 1;
  localparam int PW    = SUM_W + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

  // Configuration registers.
  logic [TICK_W-1:0]  interval_ms;
  logic [REF_W-1:0]   reference_mv;
  logic [SHIFT_W-1:0] gain_shift;

  // Pipeline control.
  logic v1, v2, v3, v4, v5, v6;
  logic acc1, acc2, acc3, acc4, acc5, acc6;
  logic r1, r2, r3, r4, r5, r6, r7;
  logic in_take, ld5, ld6, ld7;
  conv_en_t conv_en;

  // State.
  logic [TICK_W-1:0] last_measure_ms;
  logic              ring_filled;
  logic [SUM_W-1:0]  window_sum;
  logic [VAL_W-1:0]  held_mv;

  // Data path.
  logic [TICK_W-1:0] elapsed;
  logic              take_now;
  logic [VAL_W-1:0]  val4;
  logic [VAL_W-1:0]  cells [DEPTH];
  logic              cell_load;
  logic [PW-1:0]     prod6;
  logic [VAL_W-1:0]  avg6;

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ms  <= INTERVAL_RESET;
      reference_mv <= REFERENCE_RESET;
      gain_shift   <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INTERVAL:  interval_ms  <= cfg_data;
        CFG_REFERENCE: reference_mv <= cfg_data[REF_W-1:0];
        CFG_GAIN:      gain_shift   <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage ready chain: a stage may load when it is empty or its word moves on.
  assign r7 = !out_valid || !out_stall;
  assign r6 = !v6 || r7;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_stall = !r1;
  assign in_take = in_valid && r1;
  assign ld5 = v4 && r5;
  assign ld6 = v5 && r6;
  assign ld7 = v6 && r7;

  // Time gate against the last accepted measurement.
  assign elapsed  = now_ms - last_measure_ms;
  assign take_now = elapsed >= interval_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_measure_ms <= START_TICK;
    end else if (in_take && take_now) begin
      last_measure_ms <= now_ms;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
      if (r7) out_valid <= v6;
    end
  end

  // Accept flags travel with their words.
  always_ff @(posedge clk) begin
    if (in_take) acc1 <= take_now;
    if (v1 && r2) acc2 <= acc1;
    if (v2 && r3) acc3 <= acc2;
    if (v3 && r4) acc4 <= acc3;
    if (ld5) acc5 <= acc4;
    if (ld6) acc6 <= acc5;
  end

  // Conversion pipeline.
  assign conv_en.ld1 = in_take;
  assign conv_en.ld2 = v1 && r2;
  assign conv_en.ld3 = v2 && r3;
  assign conv_en.ld4 = v3 && r4;

  rlva_conv u_conv (
    .clk          (clk),
    .en           (conv_en),
    .adc_code     (adc_code),
    .reference_mv (reference_mv),
    .gain_shift   (gain_shift),
    .value        (val4)
  );

  // Window cells: the newest sample enters cell zero, the oldest leaves the last.
  assign cell_load = ld5 && acc4;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      rlva_cell u_cell (
        .clk        (clk),
        .load       (cell_load),
        .fill       (!ring_filled),
        .fill_value (val4),
        .shift_in   (val4),
        .value      (cells[i])
      );
    end else begin : g_body
      rlva_cell u_cell (
        .clk        (clk),
        .load       (cell_load),
        .fill       (!ring_filled),
        .fill_value (val4),
        .shift_in   (cells[i-1]),
        .value      (cells[i])
      );
    end
  end

  // Running window sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_filled <= 1'b0;
      window_sum  <= '0;
    end else if (cell_load) begin
      ring_filled <= 1'b1;
      if (!ring_filled) begin
        window_sum <= SUM_W'(val4) * SUM_W'(DEPTH);
      end else begin
        window_sum <= window_sum - SUM_W'(cells[DEPTH-1]) + SUM_W'(val4);
      end
    end
  end

  // Average by reciprocal multiply; the sum is stable while this word waits.
  always_ff @(posedge clk) begin
    if (ld6) begin
      prod6 <= PW'(window_sum) * PW'(RECIP);
    end
  end

  assign avg6 = prod6[SH +: VAL_W];

  // Held value and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_mv <= '0;
    end else if (ld7 && acc6) begin
      held_mv <= avg6;
    end
  end

  always_ff @(posedge clk) begin
    if (ld7) begin
      reported   <= acc6;
      voltage_mv <= acc6 ? avg6 : held_mv;
    end
  end

  // Every shown result matches the held value it was built from.
  a_out_held : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> voltage_mv == held_mv)
    else $error("output value differs from held value");

  // Once the window is filled it stays filled.
  a_filled_sticky : assert property (@(posedge clk) disable iff (rst)
    ring_filled |=> ring_filled)
    else $error("window fill flag cleared");

  // The input stalls only when the first stage holds a word.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1)
    else $error("input stalled with empty first stage");

  // The timestamp only moves on an accepted measurement.
  a_tick_update : assert property (@(posedge clk) disable iff (rst)
    !(in_valid && !in_stall) |=> $stable(last_measure_ms))
    else $error("timestamp changed without accepted trigger");

endmodule

`default_nettype wire

/* bench/tb_rate_limited_voltage_averager_unit.sv */
// ----------------------------------------------------------------------------
// Rate-limited voltage averager testbench
// Sends timestamped converter codes through the unit and predicts every
// output word in step with the input. The prediction covers the interval
// gate, the millivolt scaling and the moving-average window. Directed tests
// cover the reset defaults and the register extremes. Random phases follow,
// each with its own register setting and receiver stalls, most with sender gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rate_limited_voltage_averager_unit;

  import rlva_pkg::*;

  localparam int AVG_DEPTH = RLVA_DEPTH;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int RANDOM_PHASES = 8;
  localparam int SETTLE_CYCLES = 30;
  localparam int WATCHDOG_LIMIT = 5000;

  // Register index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  typedef struct packed {
    logic             reported;
    logic [VAL_W-1:0] voltage;
  } reading_t;

  // Clock, reset and unit ports.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TICK_W-1:0] now_ms = '0;
  logic [CODE_W-1:0] adc_code = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic reported;
  logic [VAL_W-1:0] voltage_mv;

  // Predicted registers and window state.
  logic [TICK_W-1:0] interval_reg;
  logic [REF_W-1:0] reference_reg;
  logic [SHIFT_W-1:0] gain_reg;
  logic [TICK_W-1:0] last_tick;
  logic [15:0] window_ring [AVG_DEPTH];
  int unsigned write_pos;
  bit window_full;
  logic [31:0] window_sum;
  logic [VAL_W-1:0] held_mv;

  // Readings still owed by the unit, oldest first.
  reading_t pending_readings[$];
  reading_t due;

  // Sender pacing.
  bit feeding = 1'b0;
  int gap_max = 0;
  int burst_left = 1;

  int error_count = 0;
  int idle_cycles = 0;

  // Receiver stall pattern.
  stall_mode_t stall_mode = STALL_NONE;
  int stall_run = 0;
  int stall_phase = 0;

  rate_limited_voltage_averager_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .now_ms     (now_ms),
    .adc_code   (adc_code),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reported   (reported),
    .voltage_mv (voltage_mv)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Mirror of the register file and window state after reset.
  task automatic reset_prediction();
    interval_reg = INTERVAL_RESET;
    reference_reg = REFERENCE_RESET;
    gain_reg = GAIN_RESET;
    last_tick = START_TICK;
    write_pos = 0;
    window_full = 1'b0;
    window_sum = '0;
    held_mv = '0;
  endtask

  // Gate the trigger, scale and average it, and queue the word it produces.
  task automatic predict_reading(input logic [TICK_W-1:0] tick,
                                 input logic [CODE_W-1:0] code);
    logic [31:0] elapsed;
    logic [31:0] scaled;
    logic [31:0] average;
    int unsigned shift;
    reading_t word;
    elapsed = tick - last_tick;
    word.reported = 1'b0;
    if (elapsed >= interval_reg) begin
      shift = (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;
      scaled = (32'(code) * 32'(reference_reg)) / 32'(FULL_SCALE);
      scaled = (scaled << shift) & 32'h7FFF;
      if (!window_full) begin
        // The first accepted value fills the whole window.
        for (int i = 0; i < AVG_DEPTH; i++) begin
          window_ring[i] = scaled[15:0];
        end
        window_sum = scaled * AVG_DEPTH;
        write_pos = 0;
        window_full = 1'b1;
        average = scaled;
      end else begin
        window_sum = window_sum - 32'(window_ring[write_pos]) + scaled;
        window_ring[write_pos] = scaled[15:0];
        write_pos = (write_pos + 1) % AVG_DEPTH;
        average = window_sum / AVG_DEPTH;
      end
      held_mv = average[VAL_W-1:0];
      last_tick = tick;
      word.reported = 1'b1;
    end
    word.voltage = held_mv;
    pending_readings.push_back(word);
  endtask

  // Offer one trigger, wait for it to be taken, then maybe pause the sender.
  task automatic send_trigger(input logic [TICK_W-1:0] tick, input logic [CODE_W-1:0] code);
    now_ms <= tick;
    adc_code <= code;
    in_valid <= 1'b1;
    feeding = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_reading(tick, code);
    if (gap_max != 0) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        feeding = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  // Stop sending and wait until every owed word has come out.
  task automatic await_all_readings();
    if (feeding) begin
      in_valid <= 1'b0;
      feeding = 1'b0;
    end
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INTERVAL:  interval_reg = data;
      CFG_REFERENCE: reference_reg = data[REF_W-1:0];
      CFG_GAIN:      gain_reg = data[SHIFT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reset defaults: interval gate edge, first fill and a repeated tick.
  task automatic test_reset_defaults();
    send_trigger(START_TICK + INTERVAL_RESET - 1, 12'hFFF);
    send_trigger(START_TICK + INTERVAL_RESET, 12'hFFF);
    send_trigger(START_TICK + INTERVAL_RESET, 12'h000);
    send_trigger(START_TICK + 2 * INTERVAL_RESET, 12'h800);
  endtask

  // Register extremes: zero interval, full reference, saturated gain,
  // zero reference, the largest interval and the unused index.
  task automatic test_register_extremes();
    logic [TICK_W-1:0] base;
    await_all_readings();
    write_register(CFG_INTERVAL, 32'd0);
    write_register(CFG_REFERENCE, 32'd8191);
    write_register(CFG_GAIN, 32'd3);
    send_trigger(32'hFFFF_FFFF, 12'hFFF);
    send_trigger(32'h0000_0000, 12'h000);
    send_trigger(32'hFFFF_FFFF, 12'hFFF);
    await_all_readings();
    write_register(CFG_REFERENCE, 32'hFFFF_E000);
    write_register(CFG_GAIN, 32'd0);
    send_trigger(32'h5555_5555, 12'hFFF);
    await_all_readings();
    write_register(CFG_REFERENCE, 32'd1);
    write_register(CFG_GAIN, 32'hFFFF_FFFD);
    send_trigger(32'hAAAA_AAAA, 12'hFFF);
    send_trigger(32'hAAAA_AAAB, 12'hFFE);
    await_all_readings();
    write_register(CFG_INTERVAL, 32'hFFFF_FFFF);
    write_register(CFG_SPARE, 32'hFFFF_FFFF);
    base = last_tick;
    send_trigger(base + 5, 12'h123);
    send_trigger(base - 1, 12'hABC);
    send_trigger(base, 12'h456);
  endtask

  // Twelve closely spaced triggers that push accepted values through the window.
  task automatic test_window_wrap();
    logic [TICK_W-1:0] tick;
    await_all_readings();
    write_register(CFG_INTERVAL, 32'd2);
    write_register(CFG_REFERENCE, 32'd4000);
    write_register(CFG_GAIN, 32'd2);
    tick = last_tick;
    for (int i = 0; i < 12; i++) begin
      tick = tick + $urandom_range(1, 3);
      send_trigger(tick, (i % 3 == 0) ? 12'hFFF : CODE_W'($urandom_range(0, 4095)));
    end
  endtask

  // Random phases, each with a fresh register setting and sender pacing.
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] data;
    logic [TICK_W-1:0] tick;
    logic [CODE_W-1:0] code;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      await_all_readings();
      case ($urandom_range(0, 5))
        0: data = 32'd0;
        1: data = $urandom_range(1, 20);
        2: data = $urandom_range(100, 70000);
        3: data = $urandom();
        4: data = 32'hFFFF_FFFF;
        default: data = INTERVAL_RESET;
      endcase
      write_register(CFG_INTERVAL, data);
      data = $urandom();
      case ($urandom_range(0, 3))
        0: data[REF_W-1:0] = 13'd8191;
        1: data[REF_W-1:0] = '0;
        2: data = $urandom_range(1, 8191);
        default: ;
      endcase
      write_register(CFG_REFERENCE, data);
      data = $urandom();
      write_register(CFG_GAIN, data);
      gap_max = (phase % 3 == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
        if (phase == 3 && item == ITEMS_PER_PHASE / 2) begin
          await_all_readings();
        end
        // Mostly ticks just past, just short of, or well past the interval.
        case ($urandom_range(0, 9))
          0, 1, 2, 3: tick = last_tick + interval_reg + $urandom_range(0, 3);
          4, 5: tick = last_tick + interval_reg - 1;
          6: tick = last_tick + interval_reg + $urandom_range(0, 100000);
          7: tick = last_tick;
          default: tick = $urandom();
        endcase
        case ($urandom_range(0, 9))
          0: code = '0;
          1: code = 12'hFFF;
          default: code = $urandom_range(0, 4095);
        endcase
        send_trigger(tick, code);
      end
    end
    gap_max = 0;
  endtask

  // Receiver stall pattern, switching mode every stretch of cycles.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_run = $urandom_range(20, 150);
    end else begin
      stall_run--;
    end
    stall_phase = (stall_phase + 1) % 9;
    case (stall_mode)
      STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall <= (stall_phase < 6);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 1) == 0);
      default:        out_stall <= 1'b0;
    endcase
  end

  // Compare each accepted output word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected word reported=%0d voltage_mv=%0d",
                                  reported, voltage_mv));
      end else begin
        due = pending_readings.pop_front();
        if (reported !== due.reported) begin
          report_mismatch($sformatf("reported got %0d want %0d", reported, due.reported));
        end
        if (voltage_mv !== due.voltage) begin
          report_mismatch($sformatf("voltage_mv got %0d want %0d", voltage_mv, due.voltage));
        end
      end
    end
  end

  // Watchdog: end the run when no handshake completes for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_rate_limited_voltage_averager_unit: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    reset_prediction();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_window_wrap();
    test_random_traffic();
    await_all_readings();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_rate_limited_voltage_averager_unit: clean");
    end else begin
      $display("tb_rate_limited_voltage_averager_unit: errors");
    end
    $finish;
  end

endmodule
